FILE: rtl/hmrst_pkg.sv
// ----------------------------------------------------------------------------
// hmrst_pkg: shared types and constants of the hashed multiset range-sum tree
// Request and response payloads, request and register codes, hash constants.
// ----------------------------------------------------------------------------
package hmrst_pkg;

    localparam int POS_W     = 10;
    localparam int VAL_W     = 64;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 64;

    localparam logic [1:0] REQ_SET   = 2'd0;
    localparam logic [1:0] REQ_ADD   = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HASH_SEED   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_IN_USE = 1'b1;

    localparam logic [POS_W-1:0] SIZE_RESET = 10'd1023;
    localparam logic [VAL_W-1:0] SEED_RESET = 64'h0;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    localparam logic [VAL_W-1:0] HASH_GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [VAL_W-1:0] HASH_MUL1   = 64'hbf58476d1ce4e5b9;
    localparam logic [VAL_W-1:0] HASH_MUL2   = 64'h94d049bb133111eb;
    localparam int HASH_SHIFT1 = 30;
    localparam int HASH_SHIFT2 = 27;
    localparam int HASH_SHIFT3 = 31;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] operand_value;
        logic [POS_W-1:0] range_left;
        logic [POS_W-1:0] range_right;
    } req_t;

    typedef struct packed {
        logic [VAL_W-1:0] hash_sum;
        logic             status;
    } resp_t;

endpackage

FILE: rtl/hashed_multiset_range_sum_tree_core.sv
// ----------------------------------------------------------------------------
// hashed_multiset_range_sum_tree_core: hashed slot store with a range-sum tree
// A set hashes the value and updates leaf and path to the root, an add first
// adds the operand to the slot. One request is in work at a time, set by the
// walk over the single-read-port tree memory and by the shared 32x32
// multiplier. After reset both memories are cleared, and requests are stalled
// until the clearing pass ends. Register writes are taken at any time.
// ----------------------------------------------------------------------------
module hashed_multiset_range_sum_tree_core #(
    parameter int LEAVES = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [hmrst_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hmrst_pkg::CFG_DAT_W-1:0]     cfg_data,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  hmrst_pkg::req_t                     req_data,
    output logic                                resp_valid,
    input  logic                                resp_stall,
    output hmrst_pkg::resp_t                    resp_data
);

    localparam int LW = $clog2(LEAVES);
    localparam int TW = $clog2(2 * LEAVES);
    localparam int NW = TW + 1;
    localparam int VW = hmrst_pkg::VAL_W;
    localparam int PW = hmrst_pkg::POS_W;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_SLOT_RD,
        S_SLOT_ADD,
        S_H_SEED,
        S_H_GOLD,
        S_H_XS,
        S_H_M0,
        S_H_M1,
        S_H_M2,
        S_H_M3,
        S_LEAF,
        S_U_SIB,
        S_U_SUM,
        S_Q_LEFT,
        S_Q_RIGHT,
        S_Q_SHIFT,
        S_RESP
    } state_t;

    state_t           state_reg;
    logic [TW-1:0]    clr_cnt_reg;
    logic [VW-1:0]    seed_reg;
    logic [PW-1:0]    size_reg;
    logic [PW-1:0]    pos_reg;
    logic [VW-1:0]    op_reg;
    logic [VW-1:0]    val_reg;
    logic [VW-1:0]    z_reg;
    logic [VW-1:0]    m_reg;
    logic [VW-1:0]    p_reg;
    logic             round_reg;
    logic [TW-1:0]    node_reg;
    logic [VW-1:0]    cur_reg;
    logic [NW-1:0]    lo_reg;
    logic [NW-1:0]    hi_reg;
    logic [VW-1:0]    acc_reg;
    logic             rd_pend_reg;
    logic             status_reg;
    logic             resp_valid_reg;
    hmrst_pkg::resp_t resp_data_reg;

    logic [VW-1:0]    add_a;
    logic [VW-1:0]    add_b;
    logic [VW-1:0]    add_y;
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [VW-1:0]    mul_y;
    logic [VW-1:0]    mul_c;
    logic [VW-1:0]    xs_y;
    logic [VW-1:0]    hash_out;
    logic [TW-1:0]    leaf_node;
    logic [NW-1:0]    hi_m1;
    logic             pos_ok;
    logic             range_ok;

    logic             tree_we;
    logic [TW-1:0]    tree_waddr;
    logic [VW-1:0]    tree_wdata;
    logic [TW-1:0]    tree_raddr;
    logic [VW-1:0]    tree_rdata;
    logic             slot_we;
    logic [LW-1:0]    slot_waddr;
    logic [VW-1:0]    slot_wdata;
    logic [LW-1:0]    slot_raddr;
    logic [VW-1:0]    slot_rdata;

    hmrst_ram #(
        .WIDTH (VW),
        .DEPTH (2 * LEAVES)
    ) u_tree_ram (
        .clk   (clk),
        .we    (tree_we),
        .waddr (tree_waddr),
        .wdata (tree_wdata),
        .raddr (tree_raddr),
        .rdata (tree_rdata)
    );

    hmrst_ram #(
        .WIDTH (VW),
        .DEPTH (LEAVES)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    assign req_stall  = (state_reg != S_IDLE);
    assign resp_valid = resp_valid_reg;
    assign resp_data  = resp_data_reg;

    assign pos_ok   = (req_data.position < size_reg) && (32'(req_data.position) < LEAVES);
    assign range_ok = (req_data.range_left <= req_data.range_right)
                   && (req_data.range_right <= size_reg)
                   && (32'(req_data.range_right) <= LEAVES);

    assign leaf_node = TW'(pos_reg) + TW'(LEAVES);
    assign hi_m1     = hi_reg - NW'(1);
    assign mul_c     = round_reg ? hmrst_pkg::HASH_MUL2 : hmrst_pkg::HASH_MUL1;
    assign xs_y      = round_reg ? (z_reg ^ (z_reg >> hmrst_pkg::HASH_SHIFT2))
                                 : (z_reg ^ (z_reg >> hmrst_pkg::HASH_SHIFT1));
    assign hash_out  = z_reg ^ (z_reg >> hmrst_pkg::HASH_SHIFT3);

    // The one adder is shared by the slot, hash, update and query steps, the one 32x32 multiplier by the hash steps.
    always_comb
    begin
        add_a = '0;
        add_b = '0;
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SLOT_ADD:
            begin
                add_a = slot_rdata;
                add_b = op_reg;
            end
            S_H_SEED:
            begin
                add_a = val_reg;
                add_b = seed_reg;
            end
            S_H_GOLD:
            begin
                add_a = z_reg;
                add_b = hmrst_pkg::HASH_GOLDEN;
            end
            S_H_M0:
            begin
                mul_a = z_reg[31:0];
                mul_b = mul_c[31:0];
            end
            S_H_M1:
            begin
                mul_a = z_reg[63:32];
                mul_b = mul_c[31:0];
            end
            S_H_M2:
            begin
                mul_a = z_reg[31:0];
                mul_b = mul_c[63:32];
                add_a = m_reg;
                add_b = {p_reg[31:0], 32'h0};
            end
            S_H_M3:
            begin
                add_a = m_reg;
                add_b = {p_reg[31:0], 32'h0};
            end
            S_U_SUM:
            begin
                add_a = cur_reg;
                add_b = tree_rdata;
            end
            S_Q_RIGHT, S_Q_SHIFT:
            begin
                add_a = acc_reg;
                add_b = tree_rdata;
            end
            default:
            begin
                add_a = '0;
            end
        endcase
    end

    assign add_y = add_a + add_b;
    assign mul_y = mul_a * mul_b;

    always_comb
    begin
        tree_we    = 1'b0;
        tree_waddr = '0;
        tree_wdata = '0;
        tree_raddr = '0;
        slot_we    = 1'b0;
        slot_waddr = '0;
        slot_wdata = '0;
        slot_raddr = '0;
        case (state_reg)
            S_CLEAR:
            begin
                tree_we    = 1'b1;
                tree_waddr = clr_cnt_reg;
                slot_we    = (32'(clr_cnt_reg) < LEAVES);
                slot_waddr = clr_cnt_reg[LW-1:0];
            end
            S_SLOT_RD:
            begin
                slot_raddr = LW'(pos_reg);
            end
            S_LEAF:
            begin
                tree_we    = 1'b1;
                tree_waddr = leaf_node;
                tree_wdata = hash_out;
                slot_we    = 1'b1;
                slot_waddr = LW'(pos_reg);
                slot_wdata = val_reg;
            end
            S_U_SIB:
            begin
                tree_raddr = node_reg ^ TW'(1);
            end
            S_U_SUM:
            begin
                tree_we    = 1'b1;
                tree_waddr = node_reg >> 1;
                tree_wdata = add_y;
            end
            S_Q_LEFT:
            begin
                tree_raddr = lo_reg[TW-1:0];
            end
            S_Q_RIGHT:
            begin
                tree_raddr = hi_m1[TW-1:0];
            end
            default:
            begin
                tree_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= hmrst_pkg::SEED_RESET;
            size_reg <= hmrst_pkg::SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hmrst_pkg::CFG_HASH_SEED:   seed_reg <= cfg_data;
                hmrst_pkg::CFG_SIZE_IN_USE: size_reg <= cfg_data[PW-1:0];
                default:                    size_reg <= size_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            if (resp_valid_reg && !resp_stall && (state_reg != S_RESP))
            begin
                resp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + TW'(1);
                    if (clr_cnt_reg == TW'(2 * LEAVES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        pos_reg    <= req_data.position;
                        op_reg     <= req_data.operand_value;
                        val_reg    <= req_data.operand_value;
                        acc_reg    <= '0;
                        round_reg  <= 1'b0;
                        status_reg <= hmrst_pkg::STATUS_OK;
                        lo_reg     <= NW'(req_data.range_left) + NW'(LEAVES);
                        hi_reg     <= NW'(req_data.range_right) + NW'(LEAVES);
                        case (req_data.req_type)
                            hmrst_pkg::REQ_SET:
                            begin
                                if (pos_ok)
                                begin
                                    state_reg <= S_H_SEED;
                                end
                                else
                                begin
                                    status_reg <= hmrst_pkg::STATUS_BAD;
                                    state_reg  <= S_RESP;
                                end
                            end
                            hmrst_pkg::REQ_ADD:
                            begin
                                if (pos_ok)
                                begin
                                    state_reg <= S_SLOT_RD;
                                end
                                else
                                begin
                                    status_reg <= hmrst_pkg::STATUS_BAD;
                                    state_reg  <= S_RESP;
                                end
                            end
                            hmrst_pkg::REQ_QUERY:
                            begin
                                if (range_ok)
                                begin
                                    state_reg <= S_Q_LEFT;
                                end
                                else
                                begin
                                    status_reg <= hmrst_pkg::STATUS_BAD;
                                    state_reg  <= S_RESP;
                                end
                            end
                            default:
                            begin
                                status_reg <= hmrst_pkg::STATUS_BAD;
                                state_reg  <= S_RESP;
                            end
                        endcase
                    end
                end
                S_SLOT_RD:
                begin
                    state_reg <= S_SLOT_ADD;
                end
                S_SLOT_ADD:
                begin
                    val_reg   <= add_y;
                    state_reg <= S_H_SEED;
                end
                S_H_SEED:
                begin
                    z_reg     <= add_y;
                    state_reg <= S_H_GOLD;
                end
                S_H_GOLD:
                begin
                    z_reg     <= add_y;
                    state_reg <= S_H_XS;
                end
                S_H_XS:
                begin
                    z_reg     <= xs_y;
                    state_reg <= S_H_M0;
                end
                S_H_M0:
                begin
                    p_reg     <= mul_y;
                    state_reg <= S_H_M1;
                end
                S_H_M1:
                begin
                    m_reg     <= p_reg;
                    p_reg     <= mul_y;
                    state_reg <= S_H_M2;
                end
                S_H_M2:
                begin
                    m_reg     <= add_y;
                    p_reg     <= mul_y;
                    state_reg <= S_H_M3;
                end
                S_H_M3:
                begin
                    z_reg <= add_y;
                    if (round_reg)
                    begin
                        state_reg <= S_LEAF;
                    end
                    else
                    begin
                        round_reg <= 1'b1;
                        state_reg <= S_H_XS;
                    end
                end
                S_LEAF:
                begin
                    node_reg  <= leaf_node;
                    cur_reg   <= hash_out;
                    state_reg <= S_U_SIB;
                end
                S_U_SIB:
                begin
                    if (node_reg == TW'(1))
                    begin
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_U_SUM;
                    end
                end
                S_U_SUM:
                begin
                    cur_reg   <= add_y;
                    node_reg  <= node_reg >> 1;
                    state_reg <= S_U_SIB;
                end
                S_Q_LEFT:
                begin
                    if (lo_reg >= hi_reg)
                    begin
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        rd_pend_reg <= lo_reg[0];
                        if (lo_reg[0])
                        begin
                            lo_reg <= lo_reg + NW'(1);
                        end
                        state_reg <= S_Q_RIGHT;
                    end
                end
                S_Q_RIGHT:
                begin
                    if (rd_pend_reg)
                    begin
                        acc_reg <= add_y;
                    end
                    rd_pend_reg <= hi_reg[0];
                    if (hi_reg[0])
                    begin
                        hi_reg <= hi_m1;
                    end
                    state_reg <= S_Q_SHIFT;
                end
                S_Q_SHIFT:
                begin
                    if (rd_pend_reg)
                    begin
                        acc_reg <= add_y;
                    end
                    lo_reg    <= lo_reg >> 1;
                    hi_reg    <= hi_reg >> 1;
                    state_reg <= S_Q_LEFT;
                end
                S_RESP:
                begin
                    if (!resp_valid_reg || !resp_stall)
                    begin
                        resp_valid_reg         <= 1'b1;
                        resp_data_reg.hash_sum <= acc_reg;
                        resp_data_reg.status   <= status_reg;
                        state_reg              <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg != S_IDLE))
        else $error("Accepted request did not start work.");

    a_resp_from_resp_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(resp_valid) |-> $past(state_reg == S_RESP))
        else $error("Response raised outside the response step.");

    a_tree_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        tree_we |-> (32'(tree_waddr) < 2 * LEAVES))
        else $error("Tree write beyond the memory.");

    a_update_node_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_U_SIB || state_reg == S_U_SUM) |-> (node_reg != '0))
        else $error("Tree update walked past the root.");

endmodule

FILE: rtl/hmrst_ram.sv
// ----------------------------------------------------------------------------
// hmrst_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hmrst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: dv/tb_hmrst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hmrst_checker: response checker for the hashed multiset range-sum tree
// Tracks register writes and accepted requests, keeps its own copy of the slot
// values and leaf hashes, and compares every response against the oldest
// predicted one, field by field.
// ----------------------------------------------------------------------------
module tb_hmrst_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [hmrst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hmrst_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic                            req_valid,
    input  logic                            req_stall,
    input  hmrst_pkg::req_t                 req_data,
    input  logic                            resp_valid,
    input  logic                            resp_stall,
    input  hmrst_pkg::resp_t                resp_data,
    output int                              mismatch_count,
    output int                              pending_count,
    output int                              checked_count,
    output int                              query_count,
    output int                              reject_count
);

    localparam int POS_W      = hmrst_pkg::POS_W;
    localparam int VAL_W      = hmrst_pkg::VAL_W;
    localparam int SLOTS      = 1 << POS_W;
    localparam int REPORT_MAX = 20;

    logic [VAL_W-1:0] slot_value [SLOTS];
    logic [VAL_W-1:0] leaf_hash  [SLOTS];
    logic [VAL_W-1:0] seed;
    logic [POS_W-1:0] size_limit;
    hmrst_pkg::resp_t awaited_responses [$];
    hmrst_pkg::resp_t want;

    function automatic logic [VAL_W-1:0] slot_hash(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] z;
        z = v + seed + hmrst_pkg::HASH_GOLDEN;
        z = (z ^ (z >> hmrst_pkg::HASH_SHIFT1)) * hmrst_pkg::HASH_MUL1;
        z = (z ^ (z >> hmrst_pkg::HASH_SHIFT2)) * hmrst_pkg::HASH_MUL2;
        return z ^ (z >> hmrst_pkg::HASH_SHIFT3);
    endfunction

    // Applies one request to the slot store and returns the response it owes.
    function automatic hmrst_pkg::resp_t apply_request(input hmrst_pkg::req_t r);
        hmrst_pkg::resp_t res;
        logic [VAL_W-1:0] acc;
        logic [VAL_W-1:0] next_val;
        res.hash_sum = '0;
        res.status   = hmrst_pkg::STATUS_OK;
        case (r.req_type)
            hmrst_pkg::REQ_SET, hmrst_pkg::REQ_ADD:
            begin
                if (r.position >= size_limit)
                    res.status = hmrst_pkg::STATUS_BAD;
                else
                begin
                    if (r.req_type == hmrst_pkg::REQ_SET)
                        next_val = r.operand_value;
                    else
                        next_val = slot_value[r.position] + r.operand_value;
                    slot_value[r.position] = next_val;
                    leaf_hash[r.position]  = slot_hash(next_val);
                end
            end
            hmrst_pkg::REQ_QUERY:
            begin
                if (r.range_left > r.range_right || r.range_right > size_limit)
                    res.status = hmrst_pkg::STATUS_BAD;
                else
                begin
                    acc = '0;
                    for (int i = r.range_left; i < r.range_right; i++)
                        acc += leaf_hash[i];
                    res.hash_sum = acc;
                end
            end
            default:
                res.status = hmrst_pkg::STATUS_BAD;
        endcase
        return res;
    endfunction

    task automatic flag(input string what, input logic [VAL_W-1:0] exp_val,
                        input logic [VAL_W-1:0] act_val);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_val, act_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed       = hmrst_pkg::SEED_RESET;
            size_limit = hmrst_pkg::SIZE_RESET;
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_value[i] = '0;
                leaf_hash[i]  = '0;
            end
            awaited_responses.delete();
            mismatch_count = 0;
            pending_count  = 0;
            checked_count  = 0;
            query_count    = 0;
            reject_count   = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    hmrst_pkg::CFG_HASH_SEED:   seed = cfg_data;
                    hmrst_pkg::CFG_SIZE_IN_USE: size_limit = cfg_data[POS_W-1:0];
                    default:                    ;
                endcase
            end
            if (resp_valid && !resp_stall)
            begin
                checked_count++;
                if (awaited_responses.size() == 0)
                    flag("unexpected response, hash_sum", '0, resp_data.hash_sum);
                else
                begin
                    want = awaited_responses.pop_front();
                    if (resp_data.hash_sum !== want.hash_sum)
                        flag("hash_sum", want.hash_sum, resp_data.hash_sum);
                    if (resp_data.status !== want.status)
                        flag("status", VAL_W'(want.status), VAL_W'(resp_data.status));
                end
            end
            if (req_valid && !req_stall)
            begin
                want = apply_request(req_data);
                awaited_responses.push_back(want);
                if (want.status == hmrst_pkg::STATUS_BAD)
                    reject_count++;
                else if (req_data.req_type == hmrst_pkg::REQ_QUERY)
                    query_count++;
            end
            pending_count = awaited_responses.size();
        end
    end

endmodule

FILE: dv/tb_hashed_multiset_range_sum_tree_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hashed_multiset_range_sum_tree_core: testbench of the range-sum tree core
// Drives directed and random set, add, range query and unused-type requests
// under several seed and size settings, with random request gaps, response
// stalls, one long hold-off; a separate checker predicts and compares responses.
// ----------------------------------------------------------------------------
module tb_hashed_multiset_range_sum_tree_core;

    localparam int POS_W = hmrst_pkg::POS_W;
    localparam int VAL_W = hmrst_pkg::VAL_W;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int HOLD_CYCLES    = 400;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [hmrst_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [hmrst_pkg::CFG_DAT_W-1:0] cfg_data;
    logic                            req_valid;
    logic                            req_stall;
    hmrst_pkg::req_t                 req_data;
    logic                            resp_valid;
    logic                            resp_stall;
    hmrst_pkg::resp_t                resp_data;

    int mismatch_count;
    int pending_count;
    int checked_count;
    int query_count;
    int reject_count;
    int idle_cycles;
    int settings_used;

    bit               hold_request;
    bit               steady_flow;
    logic [POS_W-1:0] cur_size;

    hashed_multiset_range_sum_tree_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .resp_valid (resp_valid),
        .resp_stall (resp_stall),
        .resp_data  (resp_data)
    );

    tb_hmrst_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_data       (req_data),
        .resp_valid     (resp_valid),
        .resp_stall     (resp_stall),
        .resp_data      (resp_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .checked_count  (checked_count),
        .query_count    (query_count),
        .reject_count   (reject_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (resp_valid && !resp_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired after %0d cycles without progress", idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int idle_length();
        if ($urandom_range(9, 0) == 0)
            return $urandom_range(60, 12);
        return $urandom_range(3, 1);
    endfunction

    initial
    begin : receiver
        resp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                resp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                resp_stall <= 1'b0;
            end
            else if (steady_flow || $urandom_range(3, 0) != 0)
                resp_stall <= 1'b0;
            else
            begin
                resp_stall <= 1'b1;
                repeat (idle_length()) @(posedge clk);
                resp_stall <= 1'b0;
            end
        end
    end

    function automatic hmrst_pkg::req_t make_request(input logic [1:0] kind,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic [VAL_W-1:0] val,
                                                     input logic [POS_W-1:0] lo,
                                                     input logic [POS_W-1:0] hi);
        hmrst_pkg::req_t r;
        r.req_type      = kind;
        r.position      = pos;
        r.operand_value = val;
        r.range_left    = lo;
        r.range_right   = hi;
        return r;
    endfunction

    function automatic hmrst_pkg::req_t random_request(input logic [POS_W-1:0] size);
        hmrst_pkg::req_t r;
        int              pick;
        int              hi;
        r.position      = POS_W'($urandom);
        r.operand_value = {$urandom, $urandom};
        r.range_left    = POS_W'($urandom);
        r.range_right   = POS_W'($urandom);
        pick = $urandom_range(99, 0);
        if (pick < 40)
            r.req_type = hmrst_pkg::REQ_SET;
        else if (pick < 65)
            r.req_type = hmrst_pkg::REQ_ADD;
        else if (pick < 96)
            r.req_type = hmrst_pkg::REQ_QUERY;
        else
            r.req_type = REQ_UNUSED;
        if (size != 0 && $urandom_range(9, 0) != 0)
        begin
            if ($urandom_range(2, 0) == 0 && size > 16)
                r.position = POS_W'($urandom_range(15, 0));
            else
                r.position = POS_W'($urandom_range(size - 1, 0));
        end
        if ($urandom_range(9, 0) != 0)
        begin
            hi = $urandom_range(size, 0);
            r.range_right = POS_W'(hi);
            r.range_left  = POS_W'($urandom_range(hi, 0));
        end
        case ($urandom_range(9, 0))
            0:       r.operand_value = '0;
            1:       r.operand_value = '1;
            2:       r.operand_value = VAL_W'($urandom_range(15, 0));
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_request(input hmrst_pkg::req_t r);
        if (!steady_flow && $urandom_range(3, 0) == 0)
        begin
            req_valid <= 1'b0;
            repeat (idle_length()) @(posedge clk);
        end
        req_data  <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic run_random(input int count);
        repeat (count)
            send_request(random_request(cur_size));
    endtask

    task automatic write_register(input logic [hmrst_pkg::CFG_IDX_W-1:0] index,
                                  input logic [hmrst_pkg::CFG_DAT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    task automatic apply_setting(input logic [hmrst_pkg::CFG_DAT_W-1:0] seed_word,
                                 input logic [hmrst_pkg::CFG_DAT_W-1:0] size_word);
        settle();
        write_register(hmrst_pkg::CFG_HASH_SEED, seed_word);
        write_register(hmrst_pkg::CFG_SIZE_IN_USE, size_word);
        cur_size = size_word[POS_W-1:0];
        settings_used++;
    endtask

    initial
    begin : stimulus
        logic [hmrst_pkg::CFG_DAT_W-1:0] size_word;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = hmrst_pkg::CFG_HASH_SEED;
        cfg_data      = '0;
        req_valid     = 1'b0;
        req_data      = '0;
        hold_request  = 1'b0;
        steady_flow   = 1'b0;
        idle_cycles   = 0;
        settings_used = 0;
        cur_size      = hmrst_pkg::SIZE_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apply_setting(hmrst_pkg::SEED_RESET,
                      {{(hmrst_pkg::CFG_DAT_W-POS_W){1'b0}}, hmrst_pkg::SIZE_RESET});
        send_request(make_request(hmrst_pkg::REQ_QUERY, 0, 0, 0, 0));
        send_request(make_request(hmrst_pkg::REQ_QUERY, 0, 0, 0, 1023));
        send_request(make_request(hmrst_pkg::REQ_SET, 0, '0, 0, 0));
        send_request(make_request(hmrst_pkg::REQ_SET, 1022, '1, 0, 0));
        send_request(make_request(hmrst_pkg::REQ_SET, 1023, 64'd5, 0, 0));
        send_request(make_request(hmrst_pkg::REQ_ADD, 0, '1, 0, 0));
        send_request(make_request(hmrst_pkg::REQ_ADD, 1022, 64'd1, 0, 0));
        send_request(make_request(hmrst_pkg::REQ_ADD, 1023, 64'd1, 0, 0));
        send_request(make_request(hmrst_pkg::REQ_QUERY, 0, 0, 0, 1023));
        send_request(make_request(hmrst_pkg::REQ_QUERY, 0, 0, 5, 3));
        send_request(make_request(hmrst_pkg::REQ_QUERY, 0, 0, 1023, 1023));
        send_request(make_request(REQ_UNUSED, 3, 64'd7, 0, 1));
        send_request(make_request(hmrst_pkg::REQ_SET, 511, 64'h8000_0000_0000_0000, 0, 0));
        send_request(make_request(hmrst_pkg::REQ_ADD, 511, '1, 0, 0));
        send_request(make_request(hmrst_pkg::REQ_QUERY, 0, 0, 511, 512));
        send_request(make_request(hmrst_pkg::REQ_QUERY, 0, 0, 0, 1));
        send_request(make_request(hmrst_pkg::REQ_QUERY, 0, 0, 1022, 1023));
        send_request(make_request(hmrst_pkg::REQ_SET, 512, 64'h5555_5555_5555_5555, 0, 0));
        send_request(make_request(hmrst_pkg::REQ_SET, 513, 64'haaaa_aaaa_aaaa_aaaa, 0, 0));
        send_request(make_request(hmrst_pkg::REQ_QUERY, 0, 0, 510, 514));
        send_request(make_request(hmrst_pkg::REQ_QUERY, 0, 0, 1, 1022));
        run_random(280);

        apply_setting('1, '0);
        run_random(30);

        apply_setting({$urandom, $urandom}, 64'd1);
        send_request(make_request(hmrst_pkg::REQ_QUERY, 0, 0, 0, 2));
        send_request(make_request(hmrst_pkg::REQ_SET, 1, 64'd9, 0, 0));
        send_request(make_request(hmrst_pkg::REQ_SET, 0, {$urandom, $urandom}, 0, 0));
        send_request(make_request(hmrst_pkg::REQ_ADD, 0, {$urandom, $urandom}, 0, 0));
        send_request(make_request(hmrst_pkg::REQ_QUERY, 0, 0, 0, 1));
        run_random(40);

        size_word = {$urandom, $urandom};
        size_word[POS_W-1:0] = POS_W'($urandom_range(1022, 2));
        apply_setting({$urandom, $urandom}, size_word);
        hold_request = 1'b1;
        run_random(320);

        size_word = {$urandom, $urandom};
        size_word[POS_W-1:0] = hmrst_pkg::SIZE_RESET;
        apply_setting({$urandom, $urandom}, size_word);
        run_random(190);
        steady_flow = 1'b1;
        run_random(190);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d responses under %0d register settings:", checked_count,
                 settings_used);
        $display("%0d accepted range queries, %0d rejected requests, rest updates",
                 query_count, reject_count);
        if (mismatch_count == 0 && pending_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
rtl/hmrst_pkg.sv
rtl/hmrst_ram.sv
rtl/hashed_multiset_range_sum_tree_core.sv
dv/tb_hmrst_checker.sv
dv/tb_hashed_multiset_range_sum_tree_core.sv
